[sv/m3inv_pkg.sv]
`timescale 1ns / 1ps
package m3inv_pkg;

   localparam int ElemW    = 16;
   localparam int NumElem  = 9;
   localparam int ProdW    = 2 * ElemW;
   localparam int CofW     = ProdW + 1;
   localparam int DpW      = ElemW + CofW;
   localparam int DetW     = DpW + 1;
   localparam int FracSh   = 28;
   localparam int NumW     = CofW + FracSh;
   localparam int QBits    = 33;
   localparam int ResW     = 32;
   localparam int WideW    = DetW + QBits;
   localparam int FifoDep  = 4;
   localparam int FifoAw   = $clog2(FifoDep);

   // cofactor j = a[i0]*a[i1] - a[i2]*a[i3], elements numbered row-major
   typedef logic [3:0] idx_type;
   localparam idx_type CofIdx [NumElem][4] = '{
      '{4'd4, 4'd8, 4'd7, 4'd5},
      '{4'd7, 4'd2, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd6, 4'd2},
      '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd3, 4'd1}
   };

   typedef struct packed {
      logic [NumElem-1:0][CofW-1:0] cof;
      logic [DetW-1:0]              det;
   } work_type;

   function automatic logic signed [ProdW-1:0] mul_ee(logic signed [ElemW-1:0] x,
                                                      logic signed [ElemW-1:0] y);
      return x * y;
   endfunction

   function automatic logic signed [DpW-1:0] mul_ec(logic signed [ElemW-1:0] x,
                                                    logic signed [CofW-1:0] y);
      logic signed [DpW-1:0] xe;
      logic signed [DpW-1:0] ye;
      xe = DpW'(x);
      ye = DpW'(y);
      return xe * ye;
   endfunction

endpackage

[sv/matrix3x3_inverse.sv]
`timescale 1ns / 1ps
// From accepted req word to rsp_tvalid: 5 front stages, one queue slot, operand prep,
// 33 quotient-bit stages, output. Throughput: one matrix per cycle when nothing stalls;
// the 33-stage restoring divider runs nine lanes.
// Back pressure stalls the back end first; the front stalls once the 4-word queue fills.
// Reset: synchronous, active high; clears valids, queue pointers and queue count only.
module matrix3x3_inverse (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22 (16b each)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22 (32b each)
   output logic [1:0]   rsp_tuser    // singular, saturated
);

   m3inv_pkg::work_type fr_word, bk_word;
   logic fr_valid, fr_ready, bk_valid, bk_ready;
   logic sing, sat;

   m3inv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_word  (fr_word)
   );

   m3inv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_word   (fr_word),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_word  (bk_word)
   );

   m3inv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (bk_valid),
      .in_ready      (bk_ready),
      .in_word       (bk_word),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp_tdata),
      .out_singular  (sing),
      .out_saturated (sat)
   );

   assign rsp_tuser = {sat, sing};

endmodule

[sv/m3inv_front.sv]
`timescale 1ns / 1ps
module m3inv_front (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [m3inv_pkg::NumElem*m3inv_pkg::ElemW-1:0]  in_data,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output m3inv_pkg::work_type                             out_word
);

   logic [4:0] vld_ff;
   logic [4:0] vld_in;
   logic       adv;

   logic signed [m3inv_pkg::ElemW-1:0] a_ff  [m3inv_pkg::NumElem];
   logic signed [m3inv_pkg::ProdW-1:0] p_ff  [m3inv_pkg::NumElem][2];
   logic signed [m3inv_pkg::ProdW-1:0] p_in  [m3inv_pkg::NumElem][2];
   logic signed [m3inv_pkg::CofW-1:0]  cof_ff  [m3inv_pkg::NumElem];
   logic signed [m3inv_pkg::CofW-1:0]  cof_in  [m3inv_pkg::NumElem];
   logic signed [m3inv_pkg::CofW-1:0]  cof4_ff [m3inv_pkg::NumElem];
   logic signed [m3inv_pkg::ElemW-1:0] r02_ff [3];
   logic signed [m3inv_pkg::ElemW-1:0] r03_ff [3];
   logic signed [m3inv_pkg::DpW-1:0]   dp_ff [3];
   logic signed [m3inv_pkg::DpW-1:0]   dp_in [3];
   logic signed [m3inv_pkg::DetW-1:0]  det_in;
   m3inv_pkg::work_type                word_ff;

   assign adv       = !vld_ff[4] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[4];
   assign out_word  = word_ff;
   assign vld_in    = {vld_ff[3:0], in_valid};

   always_comb begin
      for (int j = 0; j < m3inv_pkg::NumElem; j++) begin
         p_in[j][0] = m3inv_pkg::mul_ee(a_ff[m3inv_pkg::CofIdx[j][0]],
                                        a_ff[m3inv_pkg::CofIdx[j][1]]);
         p_in[j][1] = m3inv_pkg::mul_ee(a_ff[m3inv_pkg::CofIdx[j][2]],
                                        a_ff[m3inv_pkg::CofIdx[j][3]]);
         cof_in[j]  = m3inv_pkg::CofW'(p_ff[j][0]) - m3inv_pkg::CofW'(p_ff[j][1]);
      end
      for (int k = 0; k < 3; k++) begin
         dp_in[k] = m3inv_pkg::mul_ec(r03_ff[k], cof_ff[3*k]);
      end
      det_in = m3inv_pkg::DetW'(dp_ff[0]) + m3inv_pkg::DetW'(dp_ff[1])
             + m3inv_pkg::DetW'(dp_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < m3inv_pkg::NumElem; j++) begin
            a_ff[j]    <= in_data[j*m3inv_pkg::ElemW +: m3inv_pkg::ElemW];
            p_ff[j][0] <= p_in[j][0];
            p_ff[j][1] <= p_in[j][1];
            cof_ff[j]  <= cof_in[j];
            cof4_ff[j] <= cof_ff[j];
            word_ff.cof[j] <= cof4_ff[j];
         end
         for (int k = 0; k < 3; k++) begin
            r02_ff[k] <= a_ff[k];
            r03_ff[k] <= r02_ff[k];
            dp_ff[k]  <= dp_in[k];
         end
         word_ff.det <= det_in;
      end
   end

endmodule

[sv/m3inv_fifo.sv]
`timescale 1ns / 1ps
module m3inv_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  m3inv_pkg::work_type in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output m3inv_pkg::work_type out_word
);

   m3inv_pkg::work_type mem_ff [m3inv_pkg::FifoDep];
   logic [m3inv_pkg::FifoAw-1:0] wr_ff, rd_ff;
   logic [m3inv_pkg::FifoAw:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (m3inv_pkg::FifoAw+1)'(m3inv_pkg::FifoDep);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
   end

endmodule

[sv/m3inv_back.sv]
`timescale 1ns / 1ps
module m3inv_back (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  m3inv_pkg::work_type                            in_word,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [m3inv_pkg::NumElem*m3inv_pkg::ResW-1:0]  out_data,
   output logic                                           out_singular,
   output logic                                           out_saturated
);

   localparam int NSt = m3inv_pkg::QBits;
   localparam int NE  = m3inv_pkg::NumElem;

   logic adv;

   logic                           vld_ff  [NSt+1];
   logic                           sing_ff [NSt+1];
   logic                           sing_in [NSt+1];
   logic [m3inv_pkg::DetW-1:0]     dm_ff   [NSt+1];
   logic [m3inv_pkg::DetW-1:0]     dm_in   [NSt+1];
   logic [m3inv_pkg::NumW-1:0]     rem_ff  [NSt+1][NE];
   logic [m3inv_pkg::NumW-1:0]     rem_in  [NSt+1][NE];
   logic [m3inv_pkg::QBits-1:0]    q_ff    [NSt+1][NE];
   logic [m3inv_pkg::QBits-1:0]    q_in    [NSt+1][NE];
   logic                           neg_ff  [NSt+1][NE];
   logic                           neg_in  [NSt+1][NE];
   logic                           ovf_ff  [NSt+1][NE];
   logic                           ovf_in  [NSt+1][NE];

   logic                                          vout_ff;
   logic [NE*m3inv_pkg::ResW-1:0]                 data_ff, data_in;
   logic                                          sing_out_ff;
   logic                                          sat_ff, sat_in;

   assign adv           = !vout_ff || out_ready;
   assign in_ready      = adv;
   assign out_valid     = vout_ff;
   assign out_data      = data_ff;
   assign out_singular  = sing_out_ff;
   assign out_saturated = sat_ff;

   always_comb begin
      logic signed [m3inv_pkg::CofW-1:0] cs;
      logic signed [m3inv_pkg::DetW-1:0] ds;
      logic [m3inv_pkg::CofW-1:0]        cm;
      logic [m3inv_pkg::WideW-1:0]       dw, rw;
      logic [m3inv_pkg::QBits-1:0]       q;
      logic [m3inv_pkg::ResW-1:0]        r;
      logic                              sat_l;
      // operand prep
      ds = $signed(in_word.det);
      dm_in[0]   = ds[m3inv_pkg::DetW-1] ? m3inv_pkg::DetW'(-ds) : m3inv_pkg::DetW'(ds);
      sing_in[0] = ds == '0;
      for (int l = 0; l < NE; l++) begin
         cs = $signed(in_word.cof[l]);
         cm = cs[m3inv_pkg::CofW-1] ? m3inv_pkg::CofW'(-cs) : m3inv_pkg::CofW'(cs);
         neg_in[0][l] = cs[m3inv_pkg::CofW-1] ^ ds[m3inv_pkg::DetW-1];
         rem_in[0][l] = {cm, {m3inv_pkg::FracSh{1'b0}}};
         q_in[0][l]   = '0;
         ovf_in[0][l] = m3inv_pkg::WideW'(rem_in[0][l]) >=
                        {dm_in[0], {m3inv_pkg::QBits{1'b0}}};
      end
      // one quotient bit per stage, MSB first
      for (int s = 1; s <= NSt; s++) begin
         dm_in[s]   = dm_ff[s-1];
         sing_in[s] = sing_ff[s-1];
         for (int l = 0; l < NE; l++) begin
            dw = m3inv_pkg::WideW'(dm_ff[s-1]) << (NSt - s);
            rw = m3inv_pkg::WideW'(rem_ff[s-1][l]);
            neg_in[s][l] = neg_ff[s-1][l];
            ovf_in[s][l] = ovf_ff[s-1][l];
            if (rw >= dw) begin
               rem_in[s][l] = m3inv_pkg::NumW'(rw - dw);
               q_in[s][l]   = {q_ff[s-1][l][m3inv_pkg::QBits-2:0], 1'b1};
            end else begin
               rem_in[s][l] = rem_ff[s-1][l];
               q_in[s][l]   = {q_ff[s-1][l][m3inv_pkg::QBits-2:0], 1'b0};
            end
         end
      end
      // sign, clamp, singular
      sat_in  = 1'b0;
      data_in = '0;
      for (int l = 0; l < NE; l++) begin
         q = q_ff[NSt][l];
         if (neg_ff[NSt][l]) begin
            sat_l = ovf_ff[NSt][l] || q[m3inv_pkg::QBits-1] ||
                    (q[m3inv_pkg::ResW-1] && (q[m3inv_pkg::ResW-2:0] != '0));
            r = sat_l ? {1'b1, {(m3inv_pkg::ResW-1){1'b0}}}
                      : m3inv_pkg::ResW'(-q);
         end else begin
            sat_l = ovf_ff[NSt][l] || q[m3inv_pkg::QBits-1] || q[m3inv_pkg::ResW-1];
            r = sat_l ? {1'b0, {(m3inv_pkg::ResW-1){1'b1}}}
                      : q[m3inv_pkg::ResW-1:0];
         end
         if (sing_ff[NSt]) begin
            r     = '0;
            sat_l = 1'b0;
         end
         sat_in = sat_in | sat_l;
         data_in[l*m3inv_pkg::ResW +: m3inv_pkg::ResW] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NSt; s++) vld_ff[s] <= 1'b0;
         vout_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= NSt; s++) vld_ff[s] <= vld_ff[s-1];
         vout_ff <= vld_ff[NSt];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= NSt; s++) begin
            dm_ff[s]   <= dm_in[s];
            sing_ff[s] <= sing_in[s];
            for (int l = 0; l < NE; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               q_ff[s][l]   <= q_in[s][l];
               neg_ff[s][l] <= neg_in[s][l];
               ovf_ff[s][l] <= ovf_in[s][l];
            end
         end
         data_ff     <= data_in;
         sing_out_ff <= sing_ff[NSt];
         sat_ff      <= sat_in;
      end
   end

endmodule
